// ===== hdl/dhpk_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, hash parameters and request/result types for the pair-key
// hash table. No dependencies; every other file of the block imports this package.
package dhpk_pkg;

    localparam int TABLE_BITS  = 8;
    localparam int NUM_SLOTS   = 1 << TABLE_BITS;
    localparam int PROBE_W     = TABLE_BITS + 1;
    localparam int CNT_W       = TABLE_BITS + 1;
    localparam int KEY_W       = 32;
    localparam int SLOT_OUT_W  = 8;
    localparam int PROBE_OUT_W = 9;
    localparam int COUNT_OUT_W = 8;

    localparam logic [KEY_W-1:0] MIX_ADD = 32'h7ed55d16;
    localparam logic [KEY_W-1:0] MIX_XOR = 32'hc761c23c;
    localparam int MIX_SHL  = 12;
    localparam int MIX_SHR  = 19;
    localparam int STEP_SHL = 8;
    localparam int STEP_SHR = 4;

    localparam logic OP_PAIR  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef logic [TABLE_BITS-1:0] t_slot;

    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] parent;
        logic [KEY_W-1:0] zone;
        t_slot            idx;
        t_slot            step;
    } t_job;

    typedef struct packed {
        logic               found;
        logic               inserted;
        logic               table_full;
        t_slot              slot;
        logic [PROBE_W-1:0] probes;
        logic [CNT_W-1:0]   count;
    } t_result;

endpackage

// ===== hdl/double_hash_pair_key_table_core.sv =====
`timescale 1ns / 1ps
// Top level of the pair-key hash table: front end, request queue and probe
// engine. Depends on dhpk_pkg, dhpk_front, dhpk_fifo and dhpk_back.
//
// Usage. Requests enter through a queue-style port: a request is taken at a
// rising edge where push is high and full is low. Opcode 0 looks up the
// (parent, zone) key pair and, if it is missing, inserts it into the first
// empty slot unless the table is half full; opcode 1 empties the whole table.
// Each request yields exactly one result, presented while empty is low and
// retired by pop.
// Flow: the front end hashes over two register stages, the request then waits
// in a two-entry queue. The probe engine fetches a request, probes one slot
// per cycle through its single registered key store read port and hands the
// result to the result register; it takes no new request until then.
// Stalls: a result waiting for pop does not stop the front end; new requests
// keep entering until the queue and the hash stages are full, and only then
// is full raised. The probe engine waits with a finished result until the
// result register frees.
// Reset: all slots are invalid and the stored count is one (the root entry).
// Valid bits clear at once, so no clearing pass is needed and the first
// request may be pushed right after reset is released.
module double_hash_pair_key_table_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              i_opcode,
    input  logic [dhpk_pkg::KEY_W-1:0]        i_parent_key,
    input  logic [dhpk_pkg::KEY_W-1:0]        i_zone_key,
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_found,
    output logic                              o_inserted,
    output logic                              o_table_full,
    output logic [dhpk_pkg::SLOT_OUT_W-1:0]   o_slot_index,
    output logic [dhpk_pkg::PROBE_OUT_W-1:0]  o_probe_count,
    output logic [dhpk_pkg::COUNT_OUT_W-1:0]  o_stored_count
);
    import dhpk_pkg::*;

    // Hashed requests travel from the front end into the queue.
    t_job    front_job;
    logic    front_push;
    logic    q_full, q_empty;
    t_job    q_job;
    logic    q_pop;

    // Result register of the probe engine.
    logic    res_valid;
    t_result res;

    dhpk_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_op         (i_opcode),
        .i_parent_key (i_parent_key),
        .i_zone_key   (i_zone_key),
        .o_full       (full),
        .o_job_push   (front_push),
        .o_job        (front_job),
        .i_job_full   (q_full)
    );

    dhpk_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_job),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_job),
        .i_pop   (q_pop)
    );

    dhpk_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_pop   (pop && res_valid)
    );

    // The result fields are sized to the port widths here; the stored count
    // is reported modulo the port width, as its counter is one bit wider.
    assign empty          = !res_valid;
    assign o_found        = res.found;
    assign o_inserted     = res.inserted;
    assign o_table_full   = res.table_full;
    assign o_slot_index   = SLOT_OUT_W'(res.slot);
    assign o_probe_count  = PROBE_OUT_W'(res.probes);
    assign o_stored_count = COUNT_OUT_W'(res.count);

endmodule

// ===== hdl/dhpk_front.sv =====
`timescale 1ns / 1ps
// Front end: takes requests and computes the two-round key hash, the first
// probe slot and the odd probe step over two register stages. Uses dhpk_pkg.
module dhpk_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic                      i_op,
    input  logic [dhpk_pkg::KEY_W-1:0] i_parent_key,
    input  logic [dhpk_pkg::KEY_W-1:0] i_zone_key,
    output logic                      o_full,
    output logic                      o_job_push,
    output dhpk_pkg::t_job            o_job,
    input  logic                      i_job_full
);
    import dhpk_pkg::*;

    logic             r_v0, n_v0;
    logic             r_v1, n_v1;
    logic             r_op0, r_op1;
    logic [KEY_W-1:0] r_p0, r_z0, r_sum;
    logic [KEY_W-1:0] r_p1, r_z1, r_a1;
    logic             ready0, ready1;
    logic [KEY_W-1:0] hash, step_full;

    assign ready1 = !r_v1 || !i_job_full;
    assign ready0 = !r_v0 || ready1;
    assign o_full = !ready0;

    assign n_v0 = (i_push && ready0) || (r_v0 && !ready1);
    assign n_v1 = ready1 ? r_v0 : r_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
    end

    // Stage 0 holds the request and the key sum, stage 1 the first mix round.
    always_ff @(posedge i_clk) begin
        if (i_push && ready0) begin
            r_op0 <= i_op;
            r_p0  <= i_parent_key;
            r_z0  <= i_zone_key;
            r_sum <= i_parent_key + i_zone_key;
        end
        if (ready1 && r_v0) begin
            r_op1 <= r_op0;
            r_p1  <= r_p0;
            r_z1  <= r_z0;
            r_a1  <= r_sum + MIX_ADD + (r_sum << MIX_SHL);
        end
    end

    assign hash      = (r_a1 ^ MIX_XOR) ^ (r_a1 >> MIX_SHR);
    assign step_full = (hash << STEP_SHL) + (hash >> STEP_SHR);

    always_comb begin
        o_job.op     = r_op1;
        o_job.parent = r_p1;
        o_job.zone   = r_z1;
        o_job.idx    = hash[TABLE_BITS-1:0];
        o_job.step   = step_full[TABLE_BITS-1:0] | t_slot'(1);
    end

    assign o_job_push = r_v1 && !i_job_full;

endmodule

// ===== hdl/dhpk_fifo.sv =====
`timescale 1ns / 1ps
// Two-entry queue of hashed requests between the front end and the probe
// engine. Uses the request type of dhpk_pkg.
module dhpk_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dhpk_pkg::t_job i_data,
    output logic           o_full,
    output logic           o_empty,
    output dhpk_pkg::t_job o_data,
    input  logic           i_pop
);
    import dhpk_pkg::*;

    t_job       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("request queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("request queue read while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("request queue count out of range");
`endif

endmodule

// ===== hdl/dhpk_back.sv =====
`timescale 1ns / 1ps
// Probe engine: walks the open-addressed key table one slot per cycle, inserts
// or reports the pair, clears the table and holds the result register. Uses dhpk_pkg.
module dhpk_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  dhpk_pkg::t_job    i_job,
    output logic              o_job_pop,
    output logic              o_res_valid,
    output dhpk_pkg::t_result o_res,
    input  logic              i_res_pop
);
    import dhpk_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic [1:0]         r_state, n_state;
    t_job               r_job;
    t_slot              r_idx;
    logic [PROBE_W-1:0] r_probe;
    logic [CNT_W-1:0]   r_count;
    logic [NUM_SLOTS-1:0] r_valid;
    logic [KEY_W-1:0]   r_mem_parent [NUM_SLOTS];
    logic [KEY_W-1:0]   r_mem_zone   [NUM_SLOTS];
    logic [KEY_W-1:0]   r_rd_parent, r_rd_zone;
    t_result            r_pend, n_pend;
    t_result            r_out;
    logic               r_out_valid;

    logic               job_take;
    logic [PROBE_W-1:0] probe_n;
    logic               hit_empty, hit_match, at_limit, half_full;
    logic               do_write, probe_done, out_load;
    t_slot              step_idx, rd_addr;

    assign job_take  = (r_state == ST_IDLE) && i_job_valid;
    assign o_job_pop = job_take;

    assign probe_n   = r_probe + PROBE_W'(1);
    assign hit_empty = !r_valid[r_idx];
    assign hit_match = !hit_empty && (r_rd_parent == r_job.parent)
                       && (r_rd_zone == r_job.zone);
    assign at_limit  = (probe_n == PROBE_W'(NUM_SLOTS));
    // Refuse an insert once twice the entry count passes the slot count.
    assign half_full = ({r_count, 1'b0} > (CNT_W + 1)'(NUM_SLOTS));
    assign step_idx  = r_idx + r_job.step;
    assign rd_addr   = (r_state == ST_IDLE) ? i_job.idx : step_idx;

    assign probe_done = hit_empty || hit_match || at_limit;
    assign do_write   = (r_state == ST_CHECK) && hit_empty && !half_full;
    assign out_load   = (r_state == ST_DONE) && (!r_out_valid || i_res_pop);

    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        unique case (r_state)
            ST_IDLE: begin
                if (job_take) begin
                    if (i_job.op == OP_CLEAR) begin
                        n_pend       = '0;
                        n_pend.count = CNT_W'(1);
                        n_state      = ST_DONE;
                    end else begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (probe_done) begin
                    n_pend.found      = hit_match;
                    n_pend.inserted   = do_write;
                    n_pend.table_full = !hit_match && !do_write;
                    n_pend.slot       = (hit_match || do_write) ? r_idx : '0;
                    n_pend.probes     = probe_n;
                    n_pend.count      = do_write ? r_count + CNT_W'(1) : r_count;
                    n_state           = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_count     <= CNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (job_take && (i_job.op == OP_CLEAR)) begin
                r_valid <= '0;
                r_count <= CNT_W'(1);
            end else if (do_write) begin
                r_valid[r_idx] <= 1'b1;
                r_count        <= r_count + CNT_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (job_take) begin
            r_job   <= i_job;
            r_idx   <= i_job.idx;
            r_probe <= '0;
        end else if ((r_state == ST_CHECK) && !probe_done) begin
            r_idx   <= step_idx;
            r_probe <= probe_n;
        end
        if (out_load) begin
            r_out <= r_pend;
        end
    end

    // Key store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem_parent[r_idx] <= r_job.parent;
            r_mem_zone[r_idx]   <= r_job.zone;
        end
        r_rd_parent <= r_mem_parent[rd_addr];
        r_rd_zone   <= r_mem_zone[rd_addr];
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(1)) && (r_count <= CNT_W'(NUM_SLOTS / 2 + 1)))
        else $error("entry count out of range");
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |-> (r_probe < PROBE_W'(NUM_SLOTS)))
        else $error("probe counter passed the table size");
    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0({r_out.found, r_out.inserted, r_out.table_full}))
        else $error("result carries more than one outcome");
    a_write_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_write |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not raise the entry count");
`endif

endmodule

// ===== sim/double_hash_pair_key_table_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for double_hash_pair_key_table_core: directed and random
// lookup-or-insert and clear requests, checked against an in-bench table predictor.
// Depends on dhpk_pkg and the block's RTL only.
module double_hash_pair_key_table_core_tb;

    import dhpk_pkg::*;

    // Requests after the directed opening part, and the safety net on run length.
    // The net assumes every request probes the whole table and every result waits
    // out a long stall, then takes that several times over.
    localparam int unsigned RANDOM_REQUESTS = 1450;
    localparam int unsigned CYCLE_LIMIT     = 1_500_000;
    localparam int unsigned DRAIN_CYCLES    = 40;
    localparam int unsigned IDLE_PERCENT    = 15;
    localparam int unsigned PRINT_CAP       = 40;

    // One expected answer, at the widths of the result ports.
    typedef struct packed {
        logic                   found;
        logic                   inserted;
        logic                   table_full;
        logic [SLOT_OUT_W-1:0]  slot;
        logic [PROBE_OUT_W-1:0] probes;
        logic [COUNT_OUT_W-1:0] count;
    } table_answer_t;

    typedef struct packed {
        logic [KEY_W-1:0] parent;
        logic [KEY_W-1:0] zone;
    } key_pair_t;

    // Keeps a private copy of the slot table, predicts the answer to every
    // accepted request and matches results against the oldest prediction.
    class pair_table_scoreboard;
        bit               slot_used   [NUM_SLOTS];
        logic [KEY_W-1:0] slot_parent [NUM_SLOTS];
        logic [KEY_W-1:0] slot_zone   [NUM_SLOTS];
        int unsigned      entry_total;
        table_answer_t    pending_answers [$];
        int unsigned      mismatches;
        int unsigned      hits_seen;
        int unsigned      inserts_seen;
        int unsigned      refusals_seen;
        int unsigned      clears_seen;
        int unsigned      longest_chain;

        function new();
            wipe_table();
            mismatches    = 0;
            hits_seen     = 0;
            inserts_seen  = 0;
            refusals_seen = 0;
            clears_seen   = 0;
            longest_chain = 0;
        endfunction

        // Only the valid bits matter; key words are never read behind an
        // invalid slot. The root entry keeps the count at one.
        function void wipe_table();
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            entry_total = 1;
        endfunction

        function logic [KEY_W-1:0] pair_hash(logic [KEY_W-1:0] parent, logic [KEY_W-1:0] zone);
            logic [KEY_W-1:0] a;
            a = parent + zone;
            a = (a + MIX_ADD) + (a << MIX_SHL);
            a = (a ^ MIX_XOR) ^ (a >> MIX_SHR);
            return a;
        endfunction

        // Forced odd so that the probe walk visits every slot of the table.
        function logic [KEY_W-1:0] probe_stride(logic [KEY_W-1:0] h);
            return ((h << STEP_SHL) + (h >> STEP_SHR)) | 32'd1;
        endfunction

        function void note_request(logic op, logic [KEY_W-1:0] parent, logic [KEY_W-1:0] zone);
            table_answer_t    ans;
            logic [KEY_W-1:0] h;
            logic [KEY_W-1:0] stride_full;
            t_slot            idx;
            t_slot            stride;
            bit               open_slot;
            int unsigned      probes;
            ans = '0;
            if (op == OP_CLEAR) begin
                wipe_table();
            end else begin
                h           = pair_hash(parent, zone);
                stride_full = probe_stride(h);
                idx         = h[TABLE_BITS-1:0];
                stride      = stride_full[TABLE_BITS-1:0];
                open_slot   = 1'b0;
                probes      = 0;
                while (1) begin
                    probes++;
                    if (!slot_used[idx]) begin
                        open_slot = 1'b1;
                        break;
                    end
                    if (slot_parent[idx] == parent && slot_zone[idx] == zone) begin
                        ans.found = 1'b1;
                        ans.slot  = idx;
                        break;
                    end
                    if (probes >= NUM_SLOTS) break;
                    idx = idx + stride;
                end
                // A miss is only stored while the table stays at most half full.
                if (!ans.found) begin
                    if (!open_slot || NUM_SLOTS < 2 * entry_total) begin
                        ans.table_full = 1'b1;
                    end else begin
                        slot_used[idx]   = 1'b1;
                        slot_parent[idx] = parent;
                        slot_zone[idx]   = zone;
                        entry_total++;
                        ans.inserted = 1'b1;
                        ans.slot     = idx;
                    end
                end
                ans.probes = probes[PROBE_OUT_W-1:0];
            end
            ans.count = entry_total[COUNT_OUT_W-1:0];
            pending_answers.push_back(ans);
        endfunction

        task report_mismatch(string what);
            if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_result(table_answer_t got);
            table_answer_t want;
            if (pending_answers.size() == 0) begin
                report_mismatch("result popped with no request outstanding");
                return;
            end
            want = pending_answers.pop_front();
            if (got.found !== want.found)
                report_mismatch($sformatf("found %b, expected %b", got.found, want.found));
            if (got.inserted !== want.inserted)
                report_mismatch($sformatf("inserted %b, expected %b",
                                          got.inserted, want.inserted));
            if (got.table_full !== want.table_full)
                report_mismatch($sformatf("table_full %b, expected %b",
                                          got.table_full, want.table_full));
            if (got.slot !== want.slot)
                report_mismatch($sformatf("slot_index %0d, expected %0d", got.slot, want.slot));
            if (got.probes !== want.probes)
                report_mismatch($sformatf("probe_count %0d, expected %0d",
                                          got.probes, want.probes));
            if (got.count !== want.count)
                report_mismatch($sformatf("stored_count %0d, expected %0d",
                                          got.count, want.count));
            if (want.found) hits_seen++;
            if (want.inserted) inserts_seen++;
            if (want.table_full) refusals_seen++;
            if (want.probes == 0) clears_seen++;
            if (want.probes > longest_chain) longest_chain = want.probes;
        endtask
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    push;
    logic                    full;
    logic                    i_opcode;
    logic [KEY_W-1:0]        i_parent_key;
    logic [KEY_W-1:0]        i_zone_key;
    logic                    empty;
    logic                    pop;
    logic                    o_found;
    logic                    o_inserted;
    logic                    o_table_full;
    logic [SLOT_OUT_W-1:0]   o_slot_index;
    logic [PROBE_OUT_W-1:0]  o_probe_count;
    logic [COUNT_OUT_W-1:0]  o_stored_count;

    pair_table_scoreboard sb = new();

    // Pairs requested since the last clear; the random part draws repeats and
    // same-sum collisions from here.
    key_pair_t   live_pairs [$];
    int unsigned sent_count  = 0;
    int unsigned cycle_count = 0;
    // Set during a window of the random part in which neither side idles.
    bit          no_idle     = 1'b0;

    double_hash_pair_key_table_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_opcode       (i_opcode),
        .i_parent_key   (i_parent_key),
        .i_zone_key     (i_zone_key),
        .empty          (empty),
        .pop            (pop),
        .o_found        (o_found),
        .o_inserted     (o_inserted),
        .o_table_full   (o_table_full),
        .o_slot_index   (o_slot_index),
        .o_probe_count  (o_probe_count),
        .o_stored_count (o_stored_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Safety net: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, sb.pending_answers.size());
            $display("status: fail");
            $finish;
        end
    end

    // Result side. Outputs are read right after the edge, before the block's own
    // register updates land, so they are the values that the edge accepted.
    // The pop for the next edge is chosen at random, except in the no-idle window.
    initial begin
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty)
                sb.check_result(table_answer_t'{o_found, o_inserted, o_table_full,
                                                o_slot_index, o_probe_count,
                                                o_stored_count});
            pop <= i_rst_n && (no_idle || $urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Presents one request and holds it until an edge with full low takes it.
    // Must be entered at a rising edge; returns at the edge that accepted it, so
    // the next call can keep push high without lowering it in between.
    task automatic send_request(input logic op, input logic [KEY_W-1:0] parent,
                                input logic [KEY_W-1:0] zone);
        key_pair_t kp;
        no_idle = (sent_count >= 500 && sent_count < 760);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_opcode     <= op;
        i_parent_key <= parent;
        i_zone_key   <= zone;
        do @(posedge i_clk); while (full);
        sb.note_request(op, parent, zone);
        sent_count++;
        if (op == OP_CLEAR) begin
            live_pairs.delete();
        end else if (live_pairs.size() < 400) begin
            kp.parent = parent;
            kp.zone   = zone;
            live_pairs.push_back(kp);
        end
    endtask

    // One random round: a clear, then a run of pair requests. Most are fresh keys
    // so that long rounds fill the table to the half-full limit; the rest repeat
    // stored pairs, share a key sum with one (same hash, so long probe chains),
    // use tiny keys, or clear the table in the middle of the round.
    task automatic run_round(input int unsigned len);
        logic [KEY_W-1:0] parent;
        logic [KEY_W-1:0] zone;
        int unsigned      roll;
        key_pair_t        kp;
        send_request(OP_CLEAR, $urandom, $urandom);
        repeat (len) begin
            roll   = $urandom_range(0, 99);
            parent = $urandom;
            zone   = $urandom;
            if (live_pairs.size() != 0)
                kp = live_pairs[$urandom_range(0, live_pairs.size() - 1)];
            if (roll < 1) begin
                send_request(OP_CLEAR, parent, zone);
            end else begin
                if (roll < 28 && live_pairs.size() != 0) begin
                    parent = kp.parent;
                    zone   = kp.zone;
                end else if (roll < 44 && live_pairs.size() != 0) begin
                    zone = kp.parent + kp.zone - parent;
                end else if (roll < 48) begin
                    parent = $urandom_range(0, 7);
                    zone   = $urandom_range(0, 7);
                end
                send_request(OP_PAIR, parent, zone);
            end
        end
    endtask

    initial begin
        int unsigned directed_count;
        int unsigned round_len;
        i_rst_n      <= 1'b0;
        push         <= 1'b0;
        i_opcode     <= OP_PAIR;
        i_parent_key <= '0;
        i_zone_key   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: clear of an empty table, key extremes, a repeat that
        // must be found, pairs with equal key sums that collide on one hash,
        // and a clear followed by reinsertion of a pair that was stored before.
        send_request(OP_CLEAR, '0, '0);
        send_request(OP_PAIR, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_PAIR, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_PAIR, 32'hffff_ffff, 32'hffff_ffff);
        send_request(OP_PAIR, 32'h0000_0000, 32'hffff_ffff);
        send_request(OP_PAIR, 32'hffff_ffff, 32'h0000_0000);
        send_request(OP_PAIR, 32'h0000_0001, 32'hffff_fffe);
        send_request(OP_PAIR, 32'h8000_0000, 32'h8000_0000);
        send_request(OP_PAIR, 32'hffff_ffff, 32'h0000_0000);
        send_request(OP_PAIR, 32'h8000_0000, 32'h8000_0000);
        send_request(OP_PAIR, 32'haaaa_aaaa, 32'h5555_5555);
        send_request(OP_PAIR, 32'h5555_5555, 32'haaaa_aaaa);
        send_request(OP_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
        send_request(OP_PAIR, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_CLEAR, '0, '0);
        send_request(OP_CLEAR, '0, '0);
        directed_count = sent_count;

        // Random part: a mix of short rounds and long ones that reach the
        // half-full limit and keep probing a crowded table.
        while (sent_count < directed_count + RANDOM_REQUESTS) begin
            if ($urandom_range(0, 1) != 0)
                round_len = $urandom_range(180, 300);
            else
                round_len = $urandom_range(8, 120);
            // The last round is cut short so the run stays near its request budget.
            if (round_len > directed_count + RANDOM_REQUESTS - sent_count)
                round_len = directed_count + RANDOM_REQUESTS - sent_count;
            run_round(round_len);
        end
        push    <= 1'b0;
        no_idle  = 1'b0;

        // Drain, then give the block time to show any result nobody asked for.
        while (sb.pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d requests: %0d hits, %0d inserts, %0d refused at the half-full limit,",
                 sent_count, sb.hits_seen, sb.inserts_seen, sb.refusals_seen);
        $display("%0d clears, longest probe chain %0d slots, %0d mismatches",
                 sb.clears_seen, sb.longest_chain, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
